### rtl/core/rvm_pkg.sv
package rvm_pkg;

    localparam int DefNumRegs = 64;
    localparam int DefPcBits  = 16;
    localparam int RegIdxW    = 6;
    localparam int ImmW       = 16;
    localparam int WordW      = 64;

    localparam logic [5:0] OP_EXIT   = 6'd0;
    localparam logic [5:0] OP_JMP    = 6'd1;
    localparam logic [5:0] OP_CONDBR = 6'd2;
    localparam logic [5:0] OP_MOV    = 6'd3;
    localparam logic [5:0] OP_IMOV   = 6'd4;
    localparam logic [5:0] OP_NCONST = 6'd5;
    localparam logic [5:0] OP_NNEG   = 6'd6;
    localparam logic [5:0] OP_ADD    = 6'd7;
    localparam logic [5:0] OP_SUB    = 6'd8;
    localparam logic [5:0] OP_MUL    = 6'd9;
    localparam logic [5:0] OP_DIV    = 6'd10;
    localparam logic [5:0] OP_REM    = 6'd11;
    localparam logic [5:0] OP_SHL    = 6'd12;
    localparam logic [5:0] OP_SHR    = 6'd13;
    localparam logic [5:0] OP_POW    = 6'd14;
    localparam logic [5:0] OP_AND    = 6'd15;
    localparam logic [5:0] OP_OR     = 6'd16;
    localparam logic [5:0] OP_XOR    = 6'd17;
    localparam logic [5:0] OP_EQ     = 6'd18;
    localparam logic [5:0] OP_NE     = 6'd19;
    localparam logic [5:0] OP_LE     = 6'd20;
    localparam logic [5:0] OP_GE     = 6'd21;
    localparam logic [5:0] OP_LT     = 6'd22;
    localparam logic [5:0] OP_GT     = 6'd23;
    localparam logic [5:0] OP_DUMP   = 6'd24;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DIVZ   = 2'd1;
    localparam logic [1:0] ERR_ILLEGAL = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_POWSQ,
        S_POWMUL,
        S_FINISH,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

### rtl/core/rvm_ram.sv
module rvm_ram #(
    parameter int Width = 64,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rvm_mul.sv
module rvm_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);

    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_acc;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_part;
    logic [63:0] n_part;
    logic [31:0] w_x;
    logic [31:0] w_y;

    always_comb begin
        unique case (r_step)
            2'd0: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[31:0]; w_y = r_b[63:32]; end
        endcase
        n_part = {32'd0, w_x} * {32'd0, w_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_part <= n_part;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd1) begin
                    r_acc <= r_part;
                end else if (r_step == 2'd2) begin
                    r_acc <= r_acc + {r_part[31:0], 32'd0};
                end else if (r_step == 2'd3) begin
                    r_acc  <= r_acc + {r_part[31:0], 32'd0};
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

### rtl/core/register_vm_instruction_execute_core.sv
// Executes one bytecode instruction per input transfer against a register file
// of signed 64-bit words held in a single-port-write RAM and a program counter.
// After reset the block clears the register file and accepts no transfer
// until it is done. Only one instruction is in flight at a time.
// Most instructions pass through three registered RAM reads (both sources and
// the tested register), an execute state and a write state between input
// transfer and output transfer; the next input is taken only after the output
// transfer. Multiply adds a wait for its three 32-bit partial products, divide
// and remainder by a nonzero register run a one-bit-per-cycle restoring
// divider, and power runs a multiply and a square per exponent bit up to the
// highest set bit in the shared multiplier.
module register_vm_instruction_execute_core
    import rvm_pkg::*;
#(
    parameter int NUM_REGS = DefNumRegs,
    parameter int PC_BITS  = DefPcBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op_code[5:0], dest_reg[11:6], src_reg_one[17:12], src_reg_two[23:18],
    // immediate[39:24], pool_value[103:40]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[15:0], halted[16], exit_flag[17], error_code[19:18],
    // write_enable[20], write_index[26:21], write_value[90:27]
    output logic [95:0]  m_axis_tdata
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    t_state r_state, n_state;

    logic [5:0]        r_op;
    logic [5:0]        r_a;
    logic [5:0]        r_bi;
    logic [5:0]        r_ci;
    logic [ImmW-1:0]   r_d;
    logic [WordW-1:0]  r_pool;
    logic [WordW-1:0]  r_b;
    logic [WordW-1:0]  r_c;
    logic [WordW-1:0]  r_ta;
    logic [PC_BITS-1:0] r_pc;
    logic [AW:0]       r_clr;
    logic [6:0]        r_cnt;
    logic [WordW-1:0]  r_quo;
    logic [WordW-1:0]  r_rem;
    logic [WordW-1:0]  r_dvs;
    logic [WordW-1:0]  r_res;
    logic [WordW-1:0]  r_base;
    logic [WordW-1:0]  r_exp;
    logic [95:0]       r_out;
    logic [1:0]        r_rd;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WordW-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [WordW-1:0]  w_rdata;
    logic              w_mul_start;
    logic [WordW-1:0]  w_mul_a;
    logic [WordW-1:0]  w_mul_b;
    logic              w_mul_done;
    logic [WordW-1:0]  w_mul_p;
    logic [WordW:0]    w_trial;
    logic [5:0]        w_sel;
    logic              w_slt;
    logic [PC_BITS-1:0] w_pc1;
    logic [PC_BITS-1:0] w_npc;
    logic              w_halt;
    logic              w_exit;
    logic [1:0]        w_err;
    logic              w_wen;
    logic [WordW-1:0]  w_val;

    rvm_ram #(.Width(WordW), .Depth(1 << AW)) u_regs (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    rvm_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mul_start),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_done (w_mul_done),
        .o_p    (w_mul_p)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;
    assign w_pc1   = r_pc + PC_BITS'(1);
    assign w_slt   = ($signed(r_b) < $signed(r_c));
    assign w_trial = {1'b0, r_rem[WordW-2:0], r_quo[WordW-1]} - {1'b0, r_dvs};

    always_comb begin
        unique case (r_rd)
            2'd0:    w_sel = r_bi;
            2'd1:    w_sel = r_ci;
            default: w_sel = r_a;
        endcase
        w_raddr = AW'(w_sel);
    end

    function automatic logic idx_ok(input logic [5:0] idx);
        idx_ok = ({26'd0, idx} < NUM_REGS);
    endfunction

    always_comb begin
        w_npc  = w_pc1;
        w_halt = 1'b0;
        w_exit = 1'b0;
        w_err  = ERR_NONE;
        w_wen  = 1'b1;
        w_val  = '0;
        unique case (r_op)
            OP_EXIT: begin
                w_npc  = r_pc;
                w_halt = 1'b1;
                w_exit = (r_d != '0);
                w_wen  = 1'b0;
            end
            OP_JMP: begin
                w_npc = PC_BITS'(r_d);
                w_wen = 1'b0;
            end
            OP_CONDBR: begin
                w_wen = 1'b0;
                if (r_ta != '0) w_npc = PC_BITS'(r_d);
            end
            OP_MOV:    w_val = r_b;
            OP_IMOV:   w_val = {48'd0, r_d};
            OP_NCONST: w_val = r_pool;
            OP_NNEG:   w_val = 64'd0 - r_b;
            OP_ADD:    w_val = r_b + r_c;
            OP_SUB:    w_val = r_b - r_c;
            OP_MUL, OP_POW: w_val = r_res;
            OP_DIV, OP_REM: begin
                if (r_c == '0) begin
                    w_npc  = r_pc;
                    w_halt = 1'b1;
                    w_err  = ERR_DIVZ;
                end else begin
                    w_val = r_res;
                end
            end
            OP_SHL:    w_val = r_b << r_c[5:0];
            OP_SHR:    w_val = 64'($signed(r_b) >>> r_c[5:0]);
            OP_AND:    w_val = r_b & r_c;
            OP_OR:     w_val = r_b | r_c;
            OP_XOR:    w_val = r_b ^ r_c;
            OP_EQ:     w_val = {63'd0, (r_b == r_c)};
            OP_NE:     w_val = {63'd0, (r_b != r_c)};
            OP_LE:     w_val = {63'd0, !($signed(r_c) < $signed(r_b))};
            OP_GE:     w_val = {63'd0, !w_slt};
            OP_LT:     w_val = {63'd0, w_slt};
            OP_GT:     w_val = {63'd0, ($signed(r_c) < $signed(r_b))};
            OP_DUMP:   w_wen = 1'b0;
            default: begin
                w_npc  = r_pc;
                w_halt = 1'b1;
                w_err  = ERR_ILLEGAL;
                w_wen  = 1'b0;
            end
        endcase
        if (!idx_ok(r_a)) begin
            w_wen = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == NUM_REGS[AW:0]) n_state = S_IDLE;
            S_IDLE:   if (s_axis_tvalid) n_state = S_READ;
            S_READ:   if (r_rd == 2'd3) n_state = S_EXEC;
            S_EXEC: begin
                priority if (r_op == OP_MUL) n_state = S_MUL;
                else if ((r_op == OP_DIV || r_op == OP_REM) && r_c != '0) n_state = S_DIV;
                else if (r_op == OP_POW && !r_c[63] && r_c != '0) n_state = S_POWMUL;
                else n_state = S_WRITE;
            end
            S_MUL:    if (w_mul_done) n_state = S_WRITE;
            S_DIV:    if (r_cnt == 7'd64) n_state = S_FINISH;
            S_POWMUL: if (w_mul_done) n_state = S_POWSQ;
            S_POWSQ: begin
                if (w_mul_done) n_state = (r_exp == '0) ? S_WRITE : S_POWMUL;
            end
            S_FINISH: n_state = S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Output-side control: multiplier starts and RAM write port.
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = r_b;
        w_mul_b     = r_c;
        w_we        = 1'b0;
        w_waddr     = AW'(r_a);
        w_wdata     = r_res;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = (r_clr != NUM_REGS[AW:0]);
                w_waddr = r_clr[AW-1:0];
                w_wdata = '0;
            end
            S_EXEC: begin
                w_mul_start = (r_op == OP_MUL);
            end
            S_POWMUL: begin
                w_mul_start = (r_cnt == 7'd0);
                w_mul_a     = r_res;
                w_mul_b     = r_exp[0] ? r_base : 64'd1;
            end
            S_POWSQ: begin
                w_mul_start = (r_cnt == 7'd0);
                w_mul_a     = r_base;
                w_mul_b     = r_base;
            end
            S_WRITE: begin
                w_we    = w_wen;
                w_wdata = w_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pc    <= '0;
            r_rd    <= 2'd0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: if (r_clr != NUM_REGS[AW:0]) r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_rd <= 2'd0;
                    if (s_axis_tvalid) begin
                        r_op   <= s_axis_tdata[5:0];
                        r_a    <= s_axis_tdata[11:6];
                        r_bi   <= s_axis_tdata[17:12];
                        r_ci   <= s_axis_tdata[23:18];
                        r_d    <= s_axis_tdata[39:24];
                        r_pool <= s_axis_tdata[103:40];
                    end
                end
                S_READ: begin
                    r_rd <= r_rd + 2'd1;
                    if (r_rd == 2'd1) r_b  <= idx_ok(r_bi) ? w_rdata : '0;
                    if (r_rd == 2'd2) r_c  <= idx_ok(r_ci) ? w_rdata : '0;
                    if (r_rd == 2'd3) r_ta <= idx_ok(r_a)  ? w_rdata : '0;
                end
                S_EXEC: begin
                    r_cnt  <= '0;
                    r_quo  <= r_b[63] ? (64'd0 - r_b) : r_b;
                    r_dvs  <= r_c[63] ? (64'd0 - r_c) : r_c;
                    r_rem  <= '0;
                    r_base <= r_b;
                    r_exp  <= r_c;
                    if (r_op == OP_POW && r_c[63]) begin
                        if (r_b == 64'd1) r_res <= 64'd1;
                        else if (r_b == '1) r_res <= r_c[0] ? '1 : 64'd1;
                        else r_res <= '0;
                    end else begin
                        r_res <= 64'd1;
                    end
                end
                S_MUL: if (w_mul_done) r_res <= w_mul_p;
                S_DIV: begin
                    if (r_cnt != 7'd64) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (!w_trial[WordW]) begin
                            r_rem <= w_trial[WordW-1:0];
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[WordW-2:0], r_quo[WordW-1]};
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                    end
                end
                S_FINISH: begin
                    if (r_op == OP_DIV)
                        r_res <= (r_b[63] != r_c[63]) ? (64'd0 - r_quo) : r_quo;
                    else
                        r_res <= r_b[63] ? (64'd0 - r_rem) : r_rem;
                end
                S_POWMUL: begin
                    r_cnt <= w_mul_done ? 7'd0 : 7'd1;
                    if (w_mul_done) begin
                        r_res <= w_mul_p;
                        r_exp <= {1'b0, r_exp[63:1]};
                    end
                end
                S_POWSQ: begin
                    r_cnt <= w_mul_done ? 7'd0 : 7'd1;
                    if (w_mul_done) r_base <= w_mul_p;
                end
                S_WRITE: begin
                    r_cnt <= '0;
                    r_pc  <= w_npc;
                    r_out <= {5'd0, (w_wen ? w_val : 64'd0), (w_wen ? r_a : 6'd0), w_wen,
                              w_err, w_exit, w_halt, 16'(w_npc)};
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("output pending while input ready");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[19:18] != ERR_NONE) |-> m_axis_tdata[16])
        else $error("error without halt");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && $past(m_axis_tvalid)) |-> !m_axis_tdata[20] || !m_axis_tdata[16]
            || m_axis_tdata[19:18] == ERR_DIVZ)
        else $error("write reported on halt");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

endmodule
